FILE: rtl/cso_pkg.sv
// Types and constants shared by the cursor sprite overlay modules.
`default_nettype none

package cso_pkg;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;
  localparam int CRD_W      = 14;

  localparam logic [1:0] KIND_MONO_ROW = 2'd0;
  localparam logic [1:0] KIND_PIXEL    = 2'd1;
  localparam logic [1:0] KIND_DARKEN   = 2'd2;
  localparam logic [1:0] KIND_SCREEN   = 2'd3;

  localparam logic [1:0] SRC_PASS   = 2'd0;
  localparam logic [1:0] SRC_BODY   = 2'd1;
  localparam logic [1:0] SRC_SHADOW = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_X      = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_Y      = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_X     = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOTSPOT_Y     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURSOR_VISIBLE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHADOW_ENABLE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTLINE_INDEX = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_INDEX    = 4'd7;

  localparam logic [7:0] CLEAR_IDX     = 8'hFE;
  localparam logic [7:0] OUTLINE_RESET = 8'd10;
  localparam logic [7:0] FILL_RESET    = 8'd17;

  localparam logic signed [CRD_W-1:0] SHADOW_DX = 14'sd1;
  localparam logic signed [CRD_W-1:0] SHADOW_DY = 14'sd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  sprite_row;
    logic [4:0]  sprite_col;
    logic [31:0] mask_bits;
    logic [31:0] data_bits;
    logic [7:0]  byte_value;
    logic [7:0]  table_index;
    logic [11:0] screen_x;
    logic [11:0] screen_y;
  } cso_in_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic [1:0] pixel_source;
  } cso_out_t;

  typedef struct packed {
    logic clr;
    logic row;
    logic pix;
  } cso_wr_t;

endpackage

`default_nettype wire

FILE: rtl/cso_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module cso_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cso_sprite_mem.sv
// Sprite store: two RAM copies (body and shadow) per sprite column, with mono row expansion and two read views.
`default_nettype none

module cso_sprite_mem #(
  parameter int SIZE = 32
) (
  input  wire logic                     clk,
  input  wire cso_pkg::cso_wr_t         wr,
  input  wire logic [$clog2(SIZE)-1:0]  wr_row,
  input  wire logic [$clog2(SIZE)-1:0]  wr_col,
  input  wire logic [31:0]              mask_bits,
  input  wire logic [31:0]              data_bits,
  input  wire logic [7:0]               pix_value,
  input  wire logic [7:0]               outline_idx,
  input  wire logic [7:0]               fill_idx,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(SIZE)-1:0]  rd_body_row,
  input  wire logic [$clog2(SIZE)-1:0]  rd_body_col,
  input  wire logic [$clog2(SIZE)-1:0]  rd_shadow_row,
  input  wire logic [$clog2(SIZE)-1:0]  rd_shadow_col,
  output logic      [7:0]               body_pix,
  output logic      [7:0]               shadow_pix
);

  import cso_pkg::*;

  localparam int SW = $clog2(SIZE);

  logic [7:0]    body_q   [SIZE];
  logic [7:0]    shadow_q [SIZE];
  logic [SW-1:0] body_col_r;
  logic [SW-1:0] shadow_col_r;

  for (genvar c = 0; c < SIZE; c++) begin : g_col
    logic [7:0] mono_val;
    logic [7:0] col_wdata;
    logic       col_we;

    if (c < 32) begin : g_mono
      assign mono_val = mask_bits[31-c] ? (data_bits[31-c] ? outline_idx : fill_idx)
                                        : CLEAR_IDX;
    end else begin : g_no_mono
      assign mono_val = CLEAR_IDX;
    end

    assign col_wdata = wr.clr ? CLEAR_IDX : (wr.row ? mono_val : pix_value);
    assign col_we    = wr.clr || wr.row || (wr.pix && (wr_col == SW'(c)));

    cso_ram #(.WIDTH(8), .DEPTH(SIZE)) u_body_ram (
      .clk   (clk),
      .we    (col_we),
      .waddr (wr_row),
      .wdata (col_wdata),
      .re    (rd_en),
      .raddr (rd_body_row),
      .rdata (body_q[c])
    );

    cso_ram #(.WIDTH(8), .DEPTH(SIZE)) u_shadow_ram (
      .clk   (clk),
      .we    (col_we),
      .waddr (wr_row),
      .wdata (col_wdata),
      .re    (rd_en),
      .raddr (rd_shadow_row),
      .rdata (shadow_q[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      body_col_r   <= rd_body_col;
      shadow_col_r <= rd_shadow_col;
    end
  end

  assign body_pix   = body_q[body_col_r];
  assign shadow_pix = shadow_q[shadow_col_r];

endmodule

`default_nettype wire

FILE: rtl/cursor_sprite_overlay_top.sv
// Top level of the cursor sprite overlay: registers, address logic and result stage.
//
// The input channel carries one item per transfer: a mono sprite row, a single
// sprite pixel, a darken table entry, or a screen pixel to be composited. Only
// screen pixels produce a transfer on the output channel; loads produce none.
// Configuration registers are written through the cfg port, which is always ready,
// and must only be written while no item is in flight.
// A screen pixel is registered in the lookup stage with its hit flags and RAM reads,
// then loaded into the output register when that register is free.
// One item can be accepted every cycle while in_stall is low; the sprite columns
// each hold two RAM copies so that the body and shadow lookups happen in the same
// cycle as the darken table lookup.
// After reset the block writes transparent pixels into every sprite row using a
// row counter and holds in_stall high meanwhile; configuration writes are
// accepted during that time.
// When the receiver stalls, the result stays in the output register and one more
// screen pixel can still be taken into the lookup stage before in_stall rises.
`default_nettype none

module cursor_sprite_overlay_top #(
  parameter int SPRITE_SIZE  = 32,
  parameter int SCREEN_LIMIT = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire cso_pkg::cso_in_t                   in_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output cso_pkg::cso_out_t                       out_data,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cso_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [cso_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import cso_pkg::*;

  localparam int SW = $clog2(SPRITE_SIZE);
  localparam logic [6:0]              SIZE_ROW = 7'(SPRITE_SIZE);
  localparam logic signed [CRD_W-1:0] SIZE_S   = CRD_W'(SPRITE_SIZE);
  localparam logic [16:0]             SCR_LIM  = 17'(SCREEN_LIMIT);
  localparam logic [SW-1:0]           CLR_LAST = SW'(SPRITE_SIZE - 1);

  logic [11:0] cursor_x_r, cursor_y_r;
  logic [4:0]  hotspot_x_r, hotspot_y_r;
  logic        cursor_visible_r, shadow_enable_r;
  logic [7:0]  outline_index_r, fill_index_r;

  logic          clr_active_r;
  logic [SW-1:0] clr_cnt_r;

  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_body_hit_r, s1_shadow_hit_r;
  logic [7:0] s1_bval_r;

  logic     out_valid_r, out_valid_nxt;
  cso_out_t out_data_r, out_data_nxt;

  logic in_accept, out_en, s1_free;
  logic on_screen, row_ok, col_ok;
  logic body_hit, shadow_hit;
  logic signed [CRD_W-1:0] sx, sy, shx, shy;

  cso_wr_t    spr_wr;
  logic [7:0] body_pix, shadow_pix, dark_pix;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r       <= '0;
      cursor_y_r       <= '0;
      hotspot_x_r      <= '0;
      hotspot_y_r      <= '0;
      cursor_visible_r <= 1'b0;
      shadow_enable_r  <= 1'b0;
      outline_index_r  <= OUTLINE_RESET;
      fill_index_r     <= FILL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURSOR_X:       cursor_x_r       <= cfg_data;
        REG_CURSOR_Y:       cursor_y_r       <= cfg_data;
        REG_HOTSPOT_X:      hotspot_x_r      <= cfg_data[4:0];
        REG_HOTSPOT_Y:      hotspot_y_r      <= cfg_data[4:0];
        REG_CURSOR_VISIBLE: cursor_visible_r <= cfg_data[0];
        REG_SHADOW_ENABLE:  shadow_enable_r  <= cfg_data[0];
        REG_OUTLINE_INDEX:  outline_index_r  <= cfg_data[7:0];
        REG_FILL_INDEX:     fill_index_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else if (clr_active_r) begin
      clr_cnt_r <= clr_cnt_r + SW'(1);
      if (clr_cnt_r == CLR_LAST) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  assign out_en    = !out_valid_r || !out_stall;
  assign s1_free   = !s1_valid_r || out_en;
  assign in_stall  = clr_active_r || !s1_free;
  assign in_accept = in_valid && !in_stall;

  assign row_ok = {2'b00, in_data.sprite_row} < SIZE_ROW;
  assign col_ok = {2'b00, in_data.sprite_col} < SIZE_ROW;

  assign spr_wr.clr = clr_active_r;
  assign spr_wr.row = in_accept && (in_data.kind == KIND_MONO_ROW) && row_ok;
  assign spr_wr.pix = in_accept && (in_data.kind == KIND_PIXEL) && row_ok && col_ok;

  assign sx  = $signed({2'b00, in_data.screen_x}) - $signed({2'b00, cursor_x_r})
               + $signed({9'd0, hotspot_x_r});
  assign sy  = $signed({2'b00, in_data.screen_y}) - $signed({2'b00, cursor_y_r})
               + $signed({9'd0, hotspot_y_r});
  assign shx = sx - SHADOW_DX;
  assign shy = sy - SHADOW_DY;

  assign on_screen = ({5'd0, in_data.screen_x} < SCR_LIM) &&
                     ({5'd0, in_data.screen_y} < SCR_LIM);

  assign body_hit   = cursor_visible_r && on_screen && !sx[CRD_W-1] && !sy[CRD_W-1] &&
                      (sx < SIZE_S) && (sy < SIZE_S);
  assign shadow_hit = cursor_visible_r && shadow_enable_r && on_screen &&
                      !shx[CRD_W-1] && !shy[CRD_W-1] && (shx < SIZE_S) && (shy < SIZE_S);

  cso_sprite_mem #(.SIZE(SPRITE_SIZE)) u_sprite_mem (
    .clk           (clk),
    .wr            (spr_wr),
    .wr_row        (clr_active_r ? clr_cnt_r : SW'(in_data.sprite_row)),
    .wr_col        (SW'(in_data.sprite_col)),
    .mask_bits     (in_data.mask_bits),
    .data_bits     (in_data.data_bits),
    .pix_value     (in_data.byte_value),
    .outline_idx   (outline_index_r),
    .fill_idx      (fill_index_r),
    .rd_en         (in_accept),
    .rd_body_row   (sy[SW-1:0]),
    .rd_body_col   (sx[SW-1:0]),
    .rd_shadow_row (shy[SW-1:0]),
    .rd_shadow_col (shx[SW-1:0]),
    .body_pix      (body_pix),
    .shadow_pix    (shadow_pix)
  );

  cso_ram #(.WIDTH(8), .DEPTH(256)) u_darken_ram (
    .clk   (clk),
    .we    (in_accept && (in_data.kind == KIND_DARKEN)),
    .waddr (in_data.table_index),
    .wdata (in_data.byte_value),
    .re    (in_accept),
    .raddr (in_data.byte_value),
    .rdata (dark_pix)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_free) begin
      s1_valid_nxt = in_accept && (in_data.kind == KIND_SCREEN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_body_hit_r   <= body_hit;
      s1_shadow_hit_r <= shadow_hit;
      s1_bval_r       <= in_data.byte_value;
    end
  end

  always_comb begin
    if (s1_body_hit_r && (body_pix != CLEAR_IDX)) begin
      out_data_nxt.pixel_out    = body_pix;
      out_data_nxt.pixel_source = SRC_BODY;
    end else if (s1_shadow_hit_r && (shadow_pix != CLEAR_IDX)) begin
      out_data_nxt.pixel_out    = dark_pix;
      out_data_nxt.pixel_source = SRC_SHADOW;
    end else begin
      out_data_nxt.pixel_out    = s1_bval_r;
      out_data_nxt.pixel_source = SRC_PASS;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_en) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> in_stall)
    else $error("input accepted during sprite clear");

  a_body_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.pixel_source == SRC_BODY)) |->
      (out_data_r.pixel_out != CLEAR_IDX))
    else $error("cursor body result carries the transparent index");

  a_source_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.pixel_source != 2'd3))
    else $error("undefined pixel source code");

  a_stage_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_en) |=> s1_valid_r)
    else $error("pending screen pixel lost while output stalled");

  a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && out_stall) |-> !in_accept)
    else $error("input transfer taken with both stages full");

endmodule

`default_nettype wire
